/* rtl/work_stealing_job_dispatcher_assert.svh */
// Assertion macros for the job dispatcher.
`ifndef WORK_STEALING_JOB_DISPATCHER_ASSERT_SVH
`define WORK_STEALING_JOB_DISPATCHER_ASSERT_SVH
// implication checked every clock, off during reset
`define WSJD_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define WSJD_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/wsjd_pkg.sv */
// Package: status codes and actions for the job dispatcher.
package wsjd_pkg;
  localparam logic [1:0] ACT_SUBMIT = 2'd0;
  localparam logic [1:0] ACT_TAKE   = 2'd1;
  localparam logic [1:0] ACT_STOP   = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;
  localparam logic [2:0] ST_QUEUED          = 3'd0;
  localparam logic [2:0] ST_REFUSED_STOPPED = 3'd1;
  localparam logic [2:0] ST_REFUSED_FULL    = 3'd2;
  localparam logic [2:0] ST_RUN             = 3'd3;
  localparam logic [2:0] ST_CANCEL          = 3'd4;
  localparam logic [2:0] ST_EMPTY           = 3'd5;
  localparam logic [2:0] ST_STOP_DONE       = 3'd6;
  localparam logic [3:0] ACTIVE_RESET = 4'd8;
endpackage

/* rtl/work_stealing_job_dispatcher.sv */
// Top level: per-worker job queues in one tag memory with round-robin submit and stealing.
// A word that causes a result has it on the ports, with done, in the cycle right
// after the accepting edge (tag memory read on that edge); busy is high in that
// cycle, so no new word is taken while a result is out. The queue choice uses
// per-queue counts kept in flops; the tag memory has one synchronous port. Reset
// (rst, sync) empties all queues, sets running, rr pointer 0, active_queues 8.
module work_stealing_job_dispatcher #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action,
  input  logic [15:0]         job_tag,
  input  logic [2:0]          worker_id,
  input  logic                drain,
  output logic                done,
  output logic [2:0]          status,
  output logic [2:0]          queue_index,
  output logic [15:0]         job_out,
  output logic                stolen,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import wsjd_pkg::*;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(NUM_QUEUES + 1);
  localparam int AW = QW + PW;

  // tag memory, one port
  logic [TAG_BITS-1:0] mem [NUM_QUEUES*QUEUE_DEPTH];
  logic [PW-1:0] heads [NUM_QUEUES];
  logic [PW-1:0] tails [NUM_QUEUES];
  logic [CW-1:0] counts [NUM_QUEUES];
  logic [QW-1:0] rr;
  logic running, drain_flag;
  logic [3:0] active_queues;

  // stage-2 holding registers
  logic          pend;
  logic          pend_pop;
  logic [2:0]    p_status, p_qi;
  logic [15:0]   p_tag;
  logic          p_stolen;
  logic [TAG_BITS-1:0] rd_data;

  assign pready = 1'b1;
  assign prdata = {28'd0, active_queues};
  assign busy = pend;

  // effective ring size
  logic [NW-1:0] n;
  always_comb begin
    if (active_queues == 4'd0) n = NW'(1);
    else if (32'(active_queues) > NUM_QUEUES) n = NW'(NUM_QUEUES);
    else n = NW'(active_queues);
  end

  // ring search: at most NUM_QUEUES independent probes, first hit wins
  logic [QW-1:0] rr_eff, sub_q, take_q;
  logic          sub_hit, take_hit, take_st, worker_in;
  logic [NW:0]   sum;
  logic [QW-1:0] cand;
  logic [NW-1:0] limit;
  always_comb begin
    rr_eff = (NW'(rr) < n) ? rr : '0;
    sub_hit = 1'b0; sub_q = rr_eff;
    take_hit = 1'b0; take_q = '0; take_st = 1'b0;
    worker_in = (32'(worker_id) < 32'(n));
    limit = (!running && drain_flag) ? NW'(1) : n;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      sum = (NW+1)'(rr_eff) + (NW+1)'(i);
      if (sum >= (NW+1)'(n)) sum = sum - (NW+1)'(n);
      cand = QW'(sum);
      if (!sub_hit && (i < 32'(n)) && (32'(counts[cand]) < QUEUE_DEPTH)) begin
        sub_hit = 1'b1; sub_q = cand;
      end
      sum = (NW+1)'(worker_id) + (NW+1)'(i);
      if (sum >= (NW+1)'(n)) sum = sum - (NW+1)'(n);
      cand = QW'(sum);
      if (!take_hit && (i < 32'(limit)) && (counts[cand] != '0)) begin
        take_hit = 1'b1; take_q = cand; take_st = (i != 0);
      end
    end
  end

  logic acc;
  assign acc = start && !busy;
  logic [QW:0] rr_inc;
  assign rr_inc = (QW+1)'(rr_eff) + 1'b1;

  always_ff @(posedge clk) begin
    if (acc && action == ACT_SUBMIT && running && sub_hit)
      mem[{sub_q, tails[sub_q]}] <= TAG_BITS'(job_tag);
    if (acc && action == ACT_TAKE)
      rd_data <= mem[AW'({take_q, heads[take_q]})];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        heads[q] <= '0; tails[q] <= '0; counts[q] <= '0;
      end
      rr <= '0; running <= 1'b1; drain_flag <= 1'b0;
      active_queues <= ACTIVE_RESET; pend <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) active_queues <= pwdata[3:0];
      // the unused action code gives no word
      pend <= acc && (action != ACT_NOP);
      if (acc) begin
        case (action)
          ACT_SUBMIT: begin
            pend_pop <= 1'b0; p_stolen <= 1'b0; p_tag <= job_tag;
            if (!running) begin
              p_status <= ST_REFUSED_STOPPED; p_qi <= 3'd0;
            end else begin
              rr <= (rr_inc >= (QW+1)'(n)) ? '0 : QW'(rr_inc);
              if (sub_hit) begin
                p_status <= ST_QUEUED; p_qi <= 3'(sub_q);
                tails[sub_q] <= (32'(tails[sub_q]) == QUEUE_DEPTH-1) ? '0
                                : tails[sub_q] + 1'b1;
                counts[sub_q] <= counts[sub_q] + 1'b1;
              end else begin
                p_status <= ST_REFUSED_FULL; p_qi <= 3'(rr_eff);
              end
            end
          end
          ACT_TAKE: begin
            p_tag <= 16'd0;
            if (worker_in && take_hit) begin
              pend_pop <= 1'b1; p_qi <= 3'(take_q); p_stolen <= take_st;
              p_status <= (!running && !drain_flag) ? ST_CANCEL : ST_RUN;
              heads[take_q] <= (32'(heads[take_q]) == QUEUE_DEPTH-1) ? '0
                               : heads[take_q] + 1'b1;
              counts[take_q] <= counts[take_q] - 1'b1;
            end else begin
              pend_pop <= 1'b0; p_stolen <= 1'b0;
              p_status <= ST_EMPTY; p_qi <= worker_id;
            end
          end
          ACT_STOP: begin
            pend_pop <= 1'b0; p_stolen <= 1'b0;
            p_tag <= 16'd0; p_status <= ST_STOP_DONE; p_qi <= 3'd0;
            if (running) begin
              running <= 1'b0; drain_flag <= drain;
            end else drain_flag <= drain_flag && drain;
          end
          default: ;
        endcase
      end
    end
  end

  logic [TAG_BITS-1:0] rd_ext;
  assign rd_ext = rd_data;
  assign done = pend;
  assign status = p_status;
  assign queue_index = p_qi;
  assign job_out = pend_pop ? 16'(rd_ext) : p_tag;
  assign stolen = p_stolen;
endmodule

/* rtl/wsjd_checker.sv */
// Port-level checker for the job dispatcher, bound to the top level.
`include "work_stealing_job_dispatcher_assert.svh"
module wsjd_checker (
  input logic clk, rst, start, busy, done, stolen,
  input logic [1:0] action,
  input logic [2:0] status
);
  import wsjd_pkg::*;
  logic take_st;
  assign take_st = (status == ST_RUN) || (status == ST_CANCEL);
  `WSJD_ASSERT_NXT(a_done_after_acc, clk, rst, start && !busy && action != ACT_NOP, done)
  `WSJD_ASSERT_IMP(a_stolen_only_take, clk, rst, done && stolen, take_st)
  `WSJD_ASSERT_NXT(a_no_double_done, clk, rst, done, !done)
  `WSJD_ASSERT_IMP(a_busy_is_done, clk, rst, busy, done)
endmodule
bind work_stealing_job_dispatcher wsjd_checker u_chk (.clk(clk), .rst(rst), .start(start),
  .busy(busy), .done(done), .stolen(stolen), .action(action), .status(status));
